@@ rtl/mlrq_pkg.sv @@
// ----------------------------------------------------------------------------
// mlrq_pkg
// Shared constants, codes and types for the multilevel ready-queue scheduler.
// ----------------------------------------------------------------------------
package mlrq_pkg;

   // Geometry
   localparam int LEVELS    = 5;
   localparam int MAX_TASKS = 64;

   localparam int ID_W    = 16;
   localparam int LVL_W   = 3;
   localparam int ST_W    = 3;
   localparam int LIDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int HEAD_W  = $clog2(MAX_TASKS);
   localparam int CNT_W   = $clog2(MAX_TASKS + 1);
   localparam int DEPTH   = LEVELS * MAX_TASKS;
   localparam int ADDR_W  = $clog2(DEPTH);

   // Command codes (carried on req_tuser)
   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_SCHEDULE = 2'd1,
      CMD_REMOVE   = 2'd2,
      CMD_SET_RUN  = 2'd3
   } cmd_type;

   // Status codes (carried on rsp_tuser)
   typedef enum logic [ST_W-1:0] {
      ST_OK       = 3'd0,
      ST_BADPRIO  = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // Sequencer states, one-hot
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_EXEC  = 8'b0000_0010,
      S_SWAIT = 8'b0000_0100,
      S_RMRD  = 8'b0000_1000,
      S_RMCMP = 8'b0001_0000,
      S_SHRD  = 8'b0010_0000,
      S_SHWR  = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

endpackage

@@ rtl/multilevel_ready_queue_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler_top
// Per-level FIFO ready queues in one synchronous RAM with a weighted
// round-robin pick, task add, remove-from-anywhere and set-running.
// ----------------------------------------------------------------------------
// One command is handled at a time. Add, set-running and rejected commands
// pass through the execute and output states; schedule adds a wait state for
// the head read from the queue RAM. Remove walks its level through the
// single-read-port queue RAM, a read and a compare per entry up to the match
// and a read and a write per entry shifted behind it. The next command is
// accepted once the result sits in the output register. The queue RAM needs
// no clearing after reset.
module multilevel_ready_queue_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] task_id, [18:16] priority_req,
                                    // [19] end_current, [23:20] zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] next_task_id, [18:16] next_priority,
                                    // [23:19] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam int ID_W   = mlrq_pkg::ID_W;
   localparam int LVL_W  = mlrq_pkg::LVL_W;
   localparam int LIDX_W = mlrq_pkg::LIDX_W;
   localparam int HEAD_W = mlrq_pkg::HEAD_W;
   localparam int CNT_W  = mlrq_pkg::CNT_W;
   localparam int ADDR_W = mlrq_pkg::ADDR_W;
   localparam int LEVELS = mlrq_pkg::LEVELS;
   localparam int MAXT   = mlrq_pkg::MAX_TASKS;

   // queue slot address of offset off from the head of level lvl
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [LIDX_W-1:0] lvl,
                                                   input logic [HEAD_W-1:0] hd,
                                                   input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] p;
      p = (CNT_W+1)'(hd) + (CNT_W+1)'(off);
      if (p >= (CNT_W+1)'(MAXT)) begin
         p = p - (CNT_W+1)'(MAXT);
      end
      return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(MAXT) + ADDR_W'(p));
   endfunction

   // state
   mlrq_pkg::state_type  state_ff, state_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [LVL_W-1:0]     prio_ff, prio_in;
   logic                 end_ff, end_in;

   logic [HEAD_W-1:0]    head_ff [LEVELS];
   logic [HEAD_W-1:0]    head_in [LEVELS];
   logic [CNT_W-1:0]     len_ff  [LEVELS];
   logic [CNT_W-1:0]     len_in  [LEVELS];
   logic [CNT_W-1:0]     srv_ff  [LEVELS];
   logic [CNT_W-1:0]     srv_in  [LEVELS];

   logic [ID_W-1:0]      run_id_ff, run_id_in;
   logic [LIDX_W-1:0]    run_lvl_ff, run_lvl_in;
   logic                 run_vld_ff, run_vld_in;

   logic [CNT_W-1:0]     off_ff, off_in;

   logic [mlrq_pkg::ST_W-1:0] res_st_ff, res_st_in;
   logic [ID_W-1:0]      res_id_ff, res_id_in;
   logic [LVL_W-1:0]     res_lvl_ff, res_lvl_in;

   logic                 out_vld_ff, out_vld_in;
   logic [mlrq_pkg::ST_W-1:0] out_st_ff, out_st_in;
   logic [ID_W-1:0]      out_id_ff, out_id_in;
   logic [LVL_W-1:0]     out_lvl_ff, out_lvl_in;

   // queue RAM
   logic [ID_W-1:0]      queue_mem [mlrq_pkg::DEPTH];
   logic [ID_W-1:0]      rd_data_ff;
   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_wa, mem_ra;
   logic [ID_W-1:0]      mem_wd;

   // pick and helpers
   logic                 prio_ok;
   logic [LIDX_W-1:0]    plvl;
   logic [LIDX_W-1:0]    pidx;
   logic                 found1, any_ne;
   logic [LIDX_W-1:0]    pick1, pick2;
   logic [LIDX_W-1:0]    rl;
   logic [CNT_W-1:0]     rlen;
   logic                 out_free;

   assign pidx     = prio_ff[LIDX_W-1:0];
   assign prio_ok  = (32'(prio_ff) < 32'(LEVELS));
   assign out_free = !out_vld_ff || rsp_tready;

   // first level served in the first pass, and first non-empty level
   always_comb begin
      found1 = 1'b0;
      any_ne = 1'b0;
      pick1  = '0;
      pick2  = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (!found1 && (srv_ff[i] < len_ff[i])) begin
            found1 = 1'b1;
            pick1  = LIDX_W'(i);
         end
         if (!any_ne && (len_ff[i] != '0)) begin
            any_ne = 1'b1;
            pick2  = LIDX_W'(i);
         end
      end
   end
   assign plvl = found1 ? pick1 : pick2;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      id_in      = id_ff;
      prio_in    = prio_ff;
      end_in     = end_ff;
      head_in    = head_ff;
      len_in     = len_ff;
      srv_in     = srv_ff;
      run_id_in  = run_id_ff;
      run_lvl_in = run_lvl_ff;
      run_vld_in = run_vld_ff;
      off_in     = off_ff;
      res_st_in  = res_st_ff;
      res_id_in  = res_id_ff;
      res_lvl_in = res_lvl_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      out_st_in  = out_st_ff;
      out_id_in  = out_id_ff;
      out_lvl_in = out_lvl_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_wa     = '0;
      mem_ra     = '0;
      mem_wd     = '0;
      rl         = run_lvl_ff;
      rlen       = '0;

      case (state_ff)
         mlrq_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               id_in    = req_tdata[15:0];
               prio_in  = req_tdata[18:16];
               end_in   = req_tdata[19];
               state_in = mlrq_pkg::S_EXEC;
            end
         end

         mlrq_pkg::S_EXEC: begin
            res_st_in  = mlrq_pkg::ST_OK;
            res_id_in  = '0;
            res_lvl_in = '0;
            state_in   = mlrq_pkg::S_OUT;
            case (cmd_ff)
               mlrq_pkg::CMD_ADD: begin
                  if (!prio_ok) begin
                     res_st_in = mlrq_pkg::ST_BADPRIO;
                  end else if (len_ff[pidx] >= CNT_W'(MAXT)) begin
                     res_st_in = mlrq_pkg::ST_FULL;
                  end else begin
                     mem_we       = 1'b1;
                     mem_wa       = slot_addr(pidx, head_ff[pidx], len_ff[pidx]);
                     mem_wd       = id_ff;
                     len_in[pidx] = len_ff[pidx] + CNT_W'(1);
                  end
               end
               mlrq_pkg::CMD_SCHEDULE: begin
                  if (!any_ne) begin
                     res_st_in = mlrq_pkg::ST_EMPTY;
                  end else begin
                     // served counts: clear those passed over, bump the pick
                     for (int j = 0; j < LEVELS; j++) begin
                        if (found1) begin
                           if (LIDX_W'(j) < plvl) srv_in[j] = '0;
                        end else begin
                           srv_in[j] = '0;
                        end
                     end
                     srv_in[plvl] = (found1 ? srv_ff[plvl] : '0) + CNT_W'(1);
                     // pop the head
                     mem_re        = 1'b1;
                     mem_ra        = slot_addr(plvl, head_ff[plvl], '0);
                     head_in[plvl] = (head_ff[plvl] == HEAD_W'(MAXT - 1)) ? '0 :
                                     head_ff[plvl] + HEAD_W'(1);
                     len_in[plvl]  = len_ff[plvl] - CNT_W'(1);
                     // requeue the running task
                     rlen = len_in[rl];
                     if (run_vld_ff && !end_ff) begin
                        if (rlen >= CNT_W'(MAXT)) begin
                           res_st_in = mlrq_pkg::ST_FULL;
                        end else begin
                           mem_we     = 1'b1;
                           mem_wa     = slot_addr(rl, head_in[rl], rlen);
                           mem_wd     = run_id_ff;
                           len_in[rl] = rlen + CNT_W'(1);
                        end
                     end
                     run_lvl_in = plvl;
                     run_vld_in = 1'b1;
                     res_lvl_in = LVL_W'(plvl);
                     state_in   = mlrq_pkg::S_SWAIT;
                  end
               end
               mlrq_pkg::CMD_REMOVE: begin
                  if (!prio_ok) begin
                     res_st_in = mlrq_pkg::ST_BADPRIO;
                  end else begin
                     off_in   = '0;
                     state_in = mlrq_pkg::S_RMRD;
                  end
               end
               default: begin
                  if (!prio_ok) begin
                     res_st_in = mlrq_pkg::ST_BADPRIO;
                  end else begin
                     run_id_in  = id_ff;
                     run_lvl_in = pidx;
                     run_vld_in = 1'b1;
                  end
               end
            endcase
         end

         // head data back from the RAM
         mlrq_pkg::S_SWAIT: begin
            run_id_in = rd_data_ff;
            res_id_in = rd_data_ff;
            state_in  = mlrq_pkg::S_OUT;
         end

         // search walk
         mlrq_pkg::S_RMRD: begin
            if (off_ff == len_ff[pidx]) begin
               res_st_in = mlrq_pkg::ST_NOTFOUND;
               state_in  = mlrq_pkg::S_OUT;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = slot_addr(pidx, head_ff[pidx], off_ff);
               state_in = mlrq_pkg::S_RMCMP;
            end
         end

         mlrq_pkg::S_RMCMP: begin
            if (rd_data_ff == id_ff) begin
               state_in = mlrq_pkg::S_SHRD;
            end else begin
               off_in   = off_ff + CNT_W'(1);
               state_in = mlrq_pkg::S_RMRD;
            end
         end

         // close the gap behind the match
         mlrq_pkg::S_SHRD: begin
            if ((off_ff + CNT_W'(1)) >= len_ff[pidx]) begin
               len_in[pidx] = len_ff[pidx] - CNT_W'(1);
               res_id_in    = id_ff;
               res_lvl_in   = prio_ff;
               state_in     = mlrq_pkg::S_OUT;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = slot_addr(pidx, head_ff[pidx], off_ff + CNT_W'(1));
               state_in = mlrq_pkg::S_SHWR;
            end
         end

         mlrq_pkg::S_SHWR: begin
            mem_we   = 1'b1;
            mem_wa   = slot_addr(pidx, head_ff[pidx], off_ff);
            mem_wd   = rd_data_ff;
            off_in   = off_ff + CNT_W'(1);
            state_in = mlrq_pkg::S_SHRD;
         end

         // hand the result to the output register
         mlrq_pkg::S_OUT: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_st_in  = res_st_ff;
               out_id_in  = res_id_ff;
               out_lvl_in = res_lvl_ff;
               state_in   = mlrq_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mlrq_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mlrq_pkg::S_IDLE;
         run_vld_ff <= 1'b0;
         run_id_ff  <= '0;
         run_lvl_ff <= '0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            len_ff[i]  <= '0;
            srv_ff[i]  <= '0;
         end
      end else begin
         state_ff   <= state_in;
         run_vld_ff <= run_vld_in;
         run_id_ff  <= run_id_in;
         run_lvl_ff <= run_lvl_in;
         out_vld_ff <= out_vld_in;
         head_ff    <= head_in;
         len_ff     <= len_in;
         srv_ff     <= srv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      id_ff      <= id_in;
      prio_ff    <= prio_in;
      end_ff     <= end_in;
      off_ff     <= off_in;
      res_st_ff  <= res_st_in;
      res_id_ff  <= res_id_in;
      res_lvl_ff <= res_lvl_in;
      out_st_ff  <= out_st_in;
      out_id_ff  <= out_id_in;
      out_lvl_ff <= out_lvl_in;
   end

   // queue RAM, read-first
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= queue_mem[mem_ra];
      end
   end

   // ports
   assign req_tready = (state_ff == mlrq_pkg::S_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'b0, out_lvl_ff, out_id_ff};
   assign rsp_tuser  = out_st_ff;

`ifndef SYNTHESIS
   // level 0 never holds more than a full queue
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff[0] <= CNT_W'(MAXT))
      else $error("queue length above capacity");

   // RAM is never written while waiting for a command
   a_no_idle_wr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlrq_pkg::S_IDLE) |-> !mem_we)
      else $error("queue RAM written while idle");

   // head read data is only consumed right after a schedule pop
   a_swait_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlrq_pkg::S_SWAIT) |-> $past(state_ff == mlrq_pkg::S_EXEC && mem_re))
      else $error("schedule wait without head read");

   // a shift write always follows a shift read
   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlrq_pkg::S_SHWR) |-> $past(state_ff == mlrq_pkg::S_SHRD))
      else $error("shift write out of order");
`endif

endmodule
